@@ hw/rtl/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg : shared definitions for the printable string extractor
// Constants, result entry type and cell control type used by the extractor and its cells.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned PseMinRun   = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgW        = 16;

  localparam logic [ByteW-1:0] PseComma   = 8'h2C;
  localparam logic [ByteW-1:0] PsePrintLo = 8'h20;
  localparam logic [ByteW-1:0] PsePrintHi = 8'h7E;
  localparam logic [CfgW-1:0]  PseMaxOutRst = 16'hFFFF;

  // one result: character, marker flag, last result of its input transaction
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             marker;
    logic             last;
  } pse_entry_t;

  // per-cycle control into every output cell
  typedef struct packed {
    logic load;
    logic shift;
  } pse_cell_ctl_t;

endpackage

@@ hw/rtl/pse_pend_cell.sv @@
// ----------------------------------------------------------------------------
// pse_pend_cell : one held byte of a run start
// Takes its upstream byte (the input byte at the head) whenever the chain shifts.
// ----------------------------------------------------------------------------
module pse_pend_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [pse_pkg::ByteW-1:0] d_i,
  output logic [pse_pkg::ByteW-1:0] q_o
);
  import pse_pkg::*;

  logic [ByteW-1:0] data_q, data_d;

  assign data_d = en_i ? d_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

@@ hw/rtl/pse_out_cell.sv @@
// ----------------------------------------------------------------------------
// pse_out_cell : one slot of the output chain
// Loads a fresh result, takes its upstream neighbour on a pop, or holds.
// ----------------------------------------------------------------------------
module pse_out_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pse_pkg::pse_cell_ctl_t ctl_i,
  input  logic                   load_valid_i,
  input  pse_pkg::pse_entry_t    load_ent_i,
  input  logic                   nbr_valid_i,
  input  pse_pkg::pse_entry_t    nbr_ent_i,
  output logic                   valid_o,
  output pse_pkg::pse_entry_t    ent_o
);
  import pse_pkg::*;

  logic       valid_q, valid_d;
  pse_entry_t ent_q, ent_d;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ctl_i.load) begin
      valid_d = load_valid_i;
      ent_d   = load_ent_i;
    end else if (ctl_i.shift) begin
      valid_d = nbr_valid_i;
      ent_d   = nbr_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign valid_o = valid_q;
  assign ent_o   = ent_q;

endmodule

@@ hw/rtl/printable_string_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// printable_string_extractor_unit : printable ASCII run extraction
// Emits every printable run of at least MIN_RUN bytes, comma separated, at
// most max_output characters per buffer, and an end marker at each buffer end.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------------------
//  s_axis   | in  | tdata=byte_in, tlast=last_byte  | tvalid/tready
//  m_axis   | out | tdata=char_out, tuser=is_marker,| tvalid/tready
//           |     | tlast=last_of_item              |
//  cfg      | in  | cfg_wdata_i = max_output        | cfg_we_i, no wait
//
//  Flow: one input transaction per cycle while each byte causes at most one
//  result and the sink is ready. A run release (up to MIN_RUN bytes, plus a
//  marker at buffer end) loads the output chain and holds s_axis_tready low
//  until the chain has drained to one entry; the single output head, one
//  result per cycle while the sink is ready, sets how long that lasts.
//  Reset: run length, emitted count and chain valid bits clear; held bytes are
//  not reset. No clearing pass.
//  Stalls: s_axis_tready depends only on chain occupancy, never on
//  m_axis_tready.
//
// ----------------------------------------------------------------------------
module printable_string_extractor_unit #(
  parameter int unsigned MIN_RUN = pse_pkg::PseMinRun
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: max_output
  input  logic                      cfg_we_i,
  input  logic [pse_pkg::CfgW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] byte_in
  input  logic                      s_axis_tlast,   // last_byte
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] char_out
  output logic                      m_axis_tuser,   // [0] is_marker
  output logic                      m_axis_tlast    // last_of_item
);
  import pse_pkg::*;

  localparam int unsigned RunW   = $clog2(MIN_RUN + 1);
  localparam int unsigned CntW   = $clog2(MIN_RUN + 2);
  localparam int unsigned PendN  = MIN_RUN - 1;
  localparam int unsigned BurstN = MIN_RUN + 1;   // most results per byte
  localparam int unsigned Depth  = BurstN + 1;    // one slot of slack

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] max_q, max_d;
  logic [CfgW-1:0] cnt_q, cnt_d;
  logic [RunW-1:0] rl_q, rl_d;

  logic             accept, pop;
  logic [ByteW-1:0] b;
  logic             last, printable;
  logic             confirmed, completes;

  assign b         = s_axis_tdata;
  assign last      = s_axis_tlast;
  assign printable = (b >= PsePrintLo) && (b <= PsePrintHi);
  assign confirmed = (rl_q == RunW'(MIN_RUN));
  assign completes = (rl_q == RunW'(MIN_RUN - 1));

  // --------------------------------------------------------------------------
  // Held run start: shift chain, oldest byte ends up in the far cell
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] pend [PendN];
  logic             pend_shift;

  assign pend_shift = accept && printable && !confirmed && !completes;

  for (genvar k = 0; k < PendN; k++) begin : g_pend
    if (k == 0) begin : g_head
      pse_pend_cell u_cell (
        .clk_i (clk_i),
        .en_i  (pend_shift),
        .d_i   (b),
        .q_o   (pend[k])
      );
    end else begin : g_body
      pse_pend_cell u_cell (
        .clk_i (clk_i),
        .en_i  (pend_shift),
        .d_i   (pend[k-1]),
        .q_o   (pend[k])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Requested characters for this byte, in emission order
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] seq_ch [MIN_RUN];
  logic [CntW-1:0]  req;

  always_comb begin
    for (int j = 0; j < MIN_RUN; j++) begin
      seq_ch[j] = '0;
    end
    req = '0;
    if (printable && completes) begin
      // release the held bytes oldest first, then this byte
      for (int j = 0; j < PendN; j++) begin
        seq_ch[j] = pend[PendN-1-j];
      end
      seq_ch[MIN_RUN-1] = b;
      req = CntW'(MIN_RUN);
    end else if (printable && confirmed) begin
      seq_ch[0] = b;
      req = CntW'(1);
    end else if (!printable && confirmed) begin
      seq_ch[0] = PseComma;
      req = CntW'(1);
    end
  end

  // limit: cut the request at what is left of max_output
  logic [CfgW-1:0] room;
  logic [CntW-1:0] n_emit, n_total, n_last;

  assign room    = (cnt_q < max_q) ? (max_q - cnt_q) : '0;
  assign n_emit  = ({{(CfgW-CntW){1'b0}}, req} <= room) ? req : room[CntW-1:0];
  assign n_total = n_emit + CntW'(last);
  assign n_last  = n_total - CntW'(1);

  // --------------------------------------------------------------------------
  // Burst of results, compacted, one extra empty slot at the top
  // --------------------------------------------------------------------------
  logic       burst_vld [Depth];
  pse_entry_t burst_ent [Depth];

  for (genvar j = 0; j < Depth; j++) begin : g_burst
    logic is_char;
    if (j < MIN_RUN) begin : g_ch
      assign is_char = (CntW'(j) < n_emit);
      assign burst_ent[j].ch = is_char ? seq_ch[j] : '0;
    end else begin : g_noch
      assign is_char = 1'b0;
      assign burst_ent[j].ch = '0;
    end
    if (j < BurstN) begin : g_in
      assign burst_vld[j] = is_char || (last && (CntW'(j) == n_emit));
      assign burst_ent[j].last = (CntW'(j) == n_last);
    end else begin : g_pad
      assign burst_vld[j] = 1'b0;
      assign burst_ent[j].last = 1'b0;
    end
    assign burst_ent[j].marker = !is_char;
  end

  // --------------------------------------------------------------------------
  // Output chain of cells; slot 0 drives the master side
  // --------------------------------------------------------------------------
  logic       cell_vld [Depth];
  pse_entry_t cell_ent [Depth];
  logic       base;   // first free slot after this cycle's pop (0 or 1)

  assign pop           = cell_vld[0] && m_axis_tready;
  assign s_axis_tready = !cell_vld[1];
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign base          = cell_vld[0] && !pop;

  for (genvar i = 0; i < Depth; i++) begin : g_out
    pse_cell_ctl_t ctl;
    logic          ld_vld;
    pse_entry_t    ld_ent;
    logic          nb_vld;
    pse_entry_t    nb_ent;

    if (i == 0) begin : g_first
      assign ctl.load = accept && !base;
      assign ld_vld   = burst_vld[0];
      assign ld_ent   = burst_ent[0];
    end else begin : g_rest
      assign ctl.load = accept;
      assign ld_vld   = base ? burst_vld[i-1] : burst_vld[i];
      assign ld_ent   = base ? burst_ent[i-1] : burst_ent[i];
    end

    if (i == Depth - 1) begin : g_end
      assign nb_vld = 1'b0;
      assign nb_ent = '0;
    end else begin : g_mid
      assign nb_vld = cell_vld[i+1];
      assign nb_ent = cell_ent[i+1];
    end

    assign ctl.shift = pop;

    pse_out_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .load_valid_i (ld_vld),
      .load_ent_i   (ld_ent),
      .nbr_valid_i  (nb_vld),
      .nbr_ent_i    (nb_ent),
      .valid_o      (cell_vld[i]),
      .ent_o        (cell_ent[i])
    );
  end

  assign m_axis_tvalid = cell_vld[0];
  assign m_axis_tdata  = cell_ent[0].ch;
  assign m_axis_tuser  = cell_ent[0].marker;
  assign m_axis_tlast  = cell_ent[0].last;

  // --------------------------------------------------------------------------
  // Run length, emitted count, limit register
  // --------------------------------------------------------------------------
  always_comb begin
    rl_d  = rl_q;
    cnt_d = cnt_q;
    max_d = cfg_we_i ? cfg_wdata_i : max_q;
    if (accept) begin
      cnt_d = cnt_q + {{(CfgW-CntW){1'b0}}, n_emit};
      if (!printable) begin
        rl_d = '0;
      end else if (completes) begin
        rl_d = RunW'(MIN_RUN);
      end else if (!confirmed) begin
        rl_d = rl_q + RunW'(1);
      end
      if (last) begin
        rl_d  = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= PseMaxOutRst;
      cnt_q <= '0;
      rl_q  <= '0;
    end else begin
      max_q <= max_d;
      cnt_q <= cnt_d;
      rl_q  <= rl_d;
    end
  end

endmodule

@@ hw/rtl/pse_checker.sv @@
// ----------------------------------------------------------------------------
// pse_checker : port-level checks for the printable string extractor
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // end marker is always the final result of its transaction
  a_marker_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("marker without tlast");

  // end marker carries no character
  a_marker_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00))
    else $error("marker with non-zero data");

  // an empty output side never throttles the input
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with nothing pending");

  // stalled result holds
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind printable_string_extractor_unit pse_checker u_pse_checker (.*);
